@@ rtl/csm_pkg.sv @@
// Shared constants, types and vertex table of the cylinder side mesh generator.
`default_nettype none
package csm_pkg;

  // Fixed-point format of sine, cosine and normals
  localparam int TRIG_FRAC_BITS = 14;
  localparam int RND_SH         = 30 - TRIG_FRAC_BITS;

  // Side count limits
  localparam logic [10:0] MIN_SIDES = 11'd3;
  localparam logic [10:0] MAX_SIDES = 11'd1024;

  // Q30 constants
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] PI_Q30  = 32'hC90F_DAA2;

  // Horner divisors for the sine and cosine series, innermost first
  localparam int TRIG_STEPS = 4;
  localparam logic [7:0] SIN_DIV [TRIG_STEPS] = '{8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [TRIG_STEPS] = '{8'd90, 8'd56, 8'd30, 8'd12};
  localparam logic [31:0] SIN_RECIP [TRIG_STEPS] = '{
    32'(64'h1_0000_0000 / 72), 32'(64'h1_0000_0000 / 42),
    32'(64'h1_0000_0000 / 20), 32'(64'h1_0000_0000 / 6)
  };
  localparam logic [31:0] COS_RECIP [TRIG_STEPS] = '{
    32'(64'h1_0000_0000 / 90), 32'(64'h1_0000_0000 / 56),
    32'(64'h1_0000_0000 / 30), 32'(64'h1_0000_0000 / 12)
  };

  // Unit normal component
  localparam logic signed [15:0] NORM_ONE = 16'sd1 <<< TRIG_FRAC_BITS;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SIDE_COUNT = 2'd0,
    CFG_RADIUS     = 2'd1,
    CFG_HEIGHT     = 2'd2
  } cfg_idx_e;

  // Vertex description
  localparam logic [3:0] LAST_VTX = 4'd11;

  typedef enum logic [1:0] {
    PT_RIM_A,
    PT_RIM_B,
    PT_CENTRE
  } point_e;

  typedef enum logic [1:0] {
    NK_SIDE,
    NK_UP,
    NK_DOWN
  } normal_e;

  typedef struct packed {
    point_e  pt;
    logic    top;
    normal_e nk;
  } vtx_desc_t;

  function automatic vtx_desc_t vtx_desc(input logic [3:0] idx);
    vtx_desc_t d;
    case (idx)
      4'd0:    d = '{PT_RIM_A,  1'b0, NK_SIDE};
      4'd1:    d = '{PT_RIM_A,  1'b1, NK_SIDE};
      4'd2:    d = '{PT_RIM_B,  1'b0, NK_SIDE};
      4'd3:    d = '{PT_RIM_B,  1'b0, NK_SIDE};
      4'd4:    d = '{PT_RIM_A,  1'b1, NK_SIDE};
      4'd5:    d = '{PT_RIM_B,  1'b1, NK_SIDE};
      4'd6:    d = '{PT_RIM_B,  1'b1, NK_UP};
      4'd7:    d = '{PT_RIM_A,  1'b1, NK_UP};
      4'd8:    d = '{PT_CENTRE, 1'b1, NK_UP};
      4'd9:    d = '{PT_RIM_B,  1'b0, NK_DOWN};
      4'd10:   d = '{PT_RIM_A,  1'b0, NK_DOWN};
      default: d = '{PT_CENTRE, 1'b0, NK_DOWN};
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

@@ rtl/csm_phase.sv @@
// Pipelined index reduction and turn-fraction division for both rim angles.
`default_nettype none
module csm_phase (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [9:0]  seg_i,
  input  logic [10:0] n_i,
  output logic        valid_o,
  output logic [31:0] pa_o,
  output logic [31:0] pb_o
);
  import csm_pkg::*;

  localparam int MOD_STEPS  = 2;
  localparam int MOD_STAGES = 10 / MOD_STEPS;
  localparam int PH_STEPS   = 4;
  localparam int PH_STAGES  = 32 / PH_STEPS;

  // index modulo n, two index bits per stage
  logic       mv_q [MOD_STAGES];
  logic [9:0] mr_q [MOD_STAGES];
  logic [9:0] mi_q [MOD_STAGES];

  for (genvar s = 0; s < MOD_STAGES; s++) begin : g_mod
    logic       in_v;
    logic [9:0] in_r;
    logic [9:0] in_i;
    logic [9:0] r_d;
    logic [9:0] i_d;

    if (s == 0) begin : g_first
      assign in_v = valid_i;
      assign in_r = '0;
      assign in_i = seg_i;
    end else begin : g_next
      assign in_v = mv_q[s-1];
      assign in_r = mr_q[s-1];
      assign in_i = mi_q[s-1];
    end

    always_comb begin : c_step
      logic [10:0] t;
      r_d = in_r;
      i_d = in_i;
      for (int j = 0; j < MOD_STEPS; j++) begin
        t = {r_d, i_d[9]};
        if (t >= n_i) begin
          t = t - n_i;
        end
        r_d = t[9:0];
        i_d = {i_d[8:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[s] <= 1'b0;
      end else if (en_i) begin
        mv_q[s] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mr_q[s] <= r_d;
        mi_q[s] <= i_d;
      end
    end
  end

  // round(k * 2^32 / n): long division of the low word n/2, four bits per stage
  logic        pv_q [PH_STAGES];
  logic [9:0]  ra_q [PH_STAGES];
  logic [9:0]  rb_q [PH_STAGES];
  logic [31:0] qa_q [PH_STAGES];
  logic [31:0] qb_q [PH_STAGES];
  logic [31:0] hb_q [PH_STAGES];

  for (genvar s = 0; s < PH_STAGES; s++) begin : g_ph
    logic        in_v;
    logic [9:0]  in_ra;
    logic [9:0]  in_rb;
    logic [31:0] in_qa;
    logic [31:0] in_qb;
    logic [31:0] in_hb;
    logic [9:0]  ra_d;
    logic [9:0]  rb_d;
    logic [31:0] qa_d;
    logic [31:0] qb_d;
    logic [31:0] hb_d;

    if (s == 0) begin : g_first
      logic [9:0]  k;
      logic [10:0] k1;
      assign k     = mr_q[MOD_STAGES-1];
      assign k1    = {1'b0, k} + 11'd1;
      assign in_v  = mv_q[MOD_STAGES-1];
      assign in_ra = k;
      // next rim of the last slice wraps to angle zero
      assign in_rb = (k1 == n_i) ? 10'd0 : k1[9:0];
      assign in_qa = '0;
      assign in_qb = '0;
      assign in_hb = {22'd0, n_i[10:1]};
    end else begin : g_next
      assign in_v  = pv_q[s-1];
      assign in_ra = ra_q[s-1];
      assign in_rb = rb_q[s-1];
      assign in_qa = qa_q[s-1];
      assign in_qb = qb_q[s-1];
      assign in_hb = hb_q[s-1];
    end

    always_comb begin : c_step
      logic [10:0] ta;
      logic [10:0] tb;
      ra_d = in_ra;
      rb_d = in_rb;
      qa_d = in_qa;
      qb_d = in_qb;
      hb_d = in_hb;
      for (int j = 0; j < PH_STEPS; j++) begin
        ta = {ra_d, hb_d[31]};
        tb = {rb_d, hb_d[31]};
        qa_d = {qa_d[30:0], ta >= n_i};
        qb_d = {qb_d[30:0], tb >= n_i};
        if (ta >= n_i) begin
          ta = ta - n_i;
        end
        if (tb >= n_i) begin
          tb = tb - n_i;
        end
        ra_d = ta[9:0];
        rb_d = tb[9:0];
        hb_d = {hb_d[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[s] <= 1'b0;
      end else if (en_i) begin
        pv_q[s] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ra_q[s] <= ra_d;
        rb_q[s] <= rb_d;
        qa_q[s] <= qa_d;
        qb_q[s] <= qb_d;
        hb_q[s] <= hb_d;
      end
    end
  end

  assign valid_o = pv_q[PH_STAGES-1];
  assign pa_o    = qa_q[PH_STAGES-1];
  assign pb_o    = qb_q[PH_STAGES-1];

endmodule
`default_nettype wire

@@ rtl/csm_trig.sv @@
// Pipelined sine and cosine of a turn fraction in Q1.14.
`default_nettype none
module csm_trig (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic        [31:0] phase_i,
  output logic               valid_o,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);
  import csm_pkg::*;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } ctx_t;

  // octant reduction and angle in Q30 radians
  logic [29:0] r_in;
  logic        swap_d;
  logic [29:0] u_d;
  logic [62:0] xp;

  assign r_in   = phase_i[29:0];
  assign swap_d = r_in > 30'h2000_0000;
  assign u_d    = swap_d ? 30'(Q30_ONE - {1'b0, r_in}) : r_in;
  assign xp     = (63'(u_d) * 63'(PI_Q30)) + 63'h4000_0000;

  logic        v1_q;
  logic [29:0] x1_q;
  logic [1:0]  quad1_q;
  logic        swap1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= xp[60:31];
      quad1_q <= phase_i[31:30];
      swap1_q <= swap_d;
    end
  end

  // x squared
  logic [59:0] sq;
  logic        v2_q;
  ctx_t        ctx2_q;

  assign sq = 60'(x1_q) * 60'(x1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx2_q <= '{x: x1_q, x2: sq[59:30], quad: quad1_q, swap: swap1_q};
    end
  end

  // Horner steps: multiply, reciprocal multiply, correct and subtract
  logic        st_v   [TRIG_STEPS+1];
  ctx_t        st_ctx [TRIG_STEPS+1];
  logic [30:0] st_ts  [TRIG_STEPS+1];
  logic [30:0] st_tc  [TRIG_STEPS+1];

  assign st_v[0]   = v2_q;
  assign st_ctx[0] = ctx2_q;
  assign st_ts[0]  = Q30_ONE;
  assign st_tc[0]  = Q30_ONE;

  for (genvar j = 0; j < TRIG_STEPS; j++) begin : g_step
    logic [60:0] ps;
    logic [60:0] pc;
    logic        a_v_q;
    ctx_t        a_ctx_q;
    logic [29:0] a_ms_q;
    logic [29:0] a_mc_q;

    assign ps = 61'(st_ctx[j].x2) * 61'(st_ts[j]);
    assign pc = 61'(st_ctx[j].x2) * 61'(st_tc[j]);

    logic [61:0] rs;
    logic [61:0] rc;
    logic        b_v_q;
    ctx_t        b_ctx_q;
    logic [29:0] b_ms_q;
    logic [29:0] b_mc_q;
    logic [29:0] b_qs_q;
    logic [29:0] b_qc_q;

    assign rs = 62'(a_ms_q) * 62'(SIN_RECIP[j]);
    assign rc = 62'(a_mc_q) * 62'(COS_RECIP[j]);

    logic [37:0] rem_s;
    logic [37:0] rem_c;
    logic [29:0] qs;
    logic [29:0] qc;
    logic        c_v_q;
    ctx_t        c_ctx_q;
    logic [30:0] c_ts_q;
    logic [30:0] c_tc_q;

    // reciprocal quotient is low by at most one
    assign rem_s = 38'(b_ms_q) - 38'(b_qs_q) * 38'(SIN_DIV[j]);
    assign rem_c = 38'(b_mc_q) - 38'(b_qc_q) * 38'(COS_DIV[j]);
    assign qs    = b_qs_q + 30'(rem_s >= 38'(SIN_DIV[j]));
    assign qc    = b_qc_q + 30'(rem_c >= 38'(COS_DIV[j]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_v_q <= 1'b0;
        b_v_q <= 1'b0;
        c_v_q <= 1'b0;
      end else if (en_i) begin
        a_v_q <= st_v[j];
        b_v_q <= a_v_q;
        c_v_q <= b_v_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_ctx_q <= st_ctx[j];
        a_ms_q  <= ps[59:30];
        a_mc_q  <= pc[59:30];
        b_ctx_q <= a_ctx_q;
        b_ms_q  <= a_ms_q;
        b_mc_q  <= a_mc_q;
        b_qs_q  <= rs[61:32];
        b_qc_q  <= rc[61:32];
        c_ctx_q <= b_ctx_q;
        c_ts_q  <= Q30_ONE - 31'(qs);
        c_tc_q  <= Q30_ONE - 31'(qc);
      end
    end

    assign st_v[j+1]   = c_v_q;
    assign st_ctx[j+1] = c_ctx_q;
    assign st_ts[j+1]  = c_ts_q;
    assign st_tc[j+1]  = c_tc_q;
  end

  // final products
  logic [60:0] fs;
  logic [60:0] fc;
  logic        f1_v_q;
  logic [1:0]  f1_quad_q;
  logic        f1_swap_q;
  logic [29:0] f1_sp_q;
  logic [29:0] f1_cm_q;

  assign fs = 61'(st_ctx[TRIG_STEPS].x)  * 61'(st_ts[TRIG_STEPS]);
  assign fc = 61'(st_ctx[TRIG_STEPS].x2) * 61'(st_tc[TRIG_STEPS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else if (en_i) begin
      f1_v_q <= st_v[TRIG_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_quad_q <= st_ctx[TRIG_STEPS].quad;
      f1_swap_q <= st_ctx[TRIG_STEPS].swap;
      f1_sp_q   <= fs[59:30];
      f1_cm_q   <= fc[59:30];
    end
  end

  // round to Q1.14, undo octant swap, apply quadrant signs
  logic [30:0]        s30;
  logic [30:0]        c30;
  logic [30:0]        sv;
  logic [30:0]        cv;
  logic [30:0]        sr;
  logic [30:0]        cr;
  logic signed [15:0] s16;
  logic signed [15:0] c16;
  logic signed [15:0] sin_d;
  logic signed [15:0] cos_d;

  assign s30 = 31'(f1_sp_q);
  assign c30 = Q30_ONE - 31'(f1_cm_q >> 1);
  assign sv  = f1_swap_q ? c30 : s30;
  assign cv  = f1_swap_q ? s30 : c30;
  assign sr  = (sv + (31'd1 << (RND_SH - 1))) >> RND_SH;
  assign cr  = (cv + (31'd1 << (RND_SH - 1))) >> RND_SH;
  assign s16 = $signed(sr[15:0]);
  assign c16 = $signed(cr[15:0]);

  always_comb begin
    case (f1_quad_q)
      2'd0: begin
        sin_d = s16;
        cos_d = c16;
      end
      2'd1: begin
        sin_d = c16;
        cos_d = -s16;
      end
      2'd2: begin
        sin_d = -s16;
        cos_d = -c16;
      end
      default: begin
        sin_d = -c16;
        cos_d = s16;
      end
    endcase
  end

  logic               f2_v_q;
  logic signed [15:0] sin_q;
  logic signed [15:0] cos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_v_q <= 1'b0;
    end else if (en_i) begin
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign valid_o = f2_v_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule
`default_nettype wire

@@ rtl/cylinder_side_mesh_generator_unit.sv @@
// Top level of the cylinder side mesh generator: config, pipeline and vertex sequencer.
//
//   channel  direction  handshake                 payload
//   request  in         in_valid_i / in_stall_o   segment_index_i
//   vertex   out        out_valid_o / out_stall_i pos_x/y/z, norm_x/y/z, last_vertex
//   config   in         cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// One request yields twelve vertices, one per cycle on the output while
// out_stall_i is low; the vertex channel sets the sustained rate.
// A request passes through 13 division stages, 16 trig stages, one scaling
// stage, the sequencer and the output register before its first vertex leaves.
// Reset restores side_count 32, radius 256, height 512 and empties the pipeline.
// A stalled output holds the sequencer, and the pipeline stops once its last stage holds an item; nothing is dropped.
`default_nettype none
module cylinder_side_mesh_generator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [9:0]         segment_index_i,
  // vertex channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [17:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [17:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic               last_vertex_o
);
  import csm_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [10:0] side_count_q;
  logic [15:0] radius_q;
  logic [15:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_count_q <= 11'd32;
      radius_q     <= 16'd256;
      height_q     <= 16'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIDE_COUNT: side_count_q <= cfg_wdata_i[10:0];
        CFG_RADIUS:     radius_q     <= cfg_wdata_i;
        CFG_HEIGHT:     height_q     <= cfg_wdata_i;
        default:        ;  // drop writes to unknown indexes
      endcase
    end
  end

  // clamp the side count into the supported range
  logic [10:0] n_eff;
  assign n_eff = (side_count_q < MIN_SIDES) ? MIN_SIDES :
                 (side_count_q > MAX_SIDES) ? MAX_SIDES : side_count_q;

  // ---------------------------------------------------------------------------
  // Pipeline enable: advance unless the last stage holds an item the
  // sequencer cannot take
  // ---------------------------------------------------------------------------
  logic en;
  logic sc_valid_q;
  logic seq_load;
  logic out_load;
  logic busy_q;
  logic [3:0] cnt_q;

  assign out_load   = !out_valid_o || !out_stall_i;
  assign seq_load   = sc_valid_q && (!busy_q || (cnt_q == LAST_VTX && out_load));
  assign en         = !sc_valid_q || seq_load;
  assign in_stall_o = !en;

  // ---------------------------------------------------------------------------
  // Index reduction and both rim angles as turn fractions
  // ---------------------------------------------------------------------------
  logic        ph_valid;
  logic [31:0] pa;
  logic [31:0] pb;

  csm_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .seg_i   (segment_index_i),
    .n_i     (n_eff),
    .valid_o (ph_valid),
    .pa_o    (pa),
    .pb_o    (pb)
  );

  // ---------------------------------------------------------------------------
  // Sine and cosine of both rim angles, one lane each
  // ---------------------------------------------------------------------------
  logic               tr_a_valid;
  logic               tr_b_valid;
  logic signed [15:0] sin_a;
  logic signed [15:0] cos_a;
  logic signed [15:0] sin_b;
  logic signed [15:0] cos_b;

  csm_trig u_trig_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ph_valid),
    .phase_i (pa),
    .valid_o (tr_a_valid),
    .sin_o   (sin_a),
    .cos_o   (cos_a)
  );

  csm_trig u_trig_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ph_valid),
    .phase_i (pb),
    .valid_o (tr_b_valid),
    .sin_o   (sin_b),
    .cos_o   (cos_b)
  );

  // ---------------------------------------------------------------------------
  // Position scaling: round(2 * R * |t| / 2^14) with the sign of t
  // ---------------------------------------------------------------------------
  function automatic logic signed [17:0] scale_pos(input logic signed [15:0] t,
                                                   input logic [15:0] r);
    logic [15:0] mag;
    logic [32:0] p;
    logic [32:0] v;
    mag = t[15] ? 16'(-t) : 16'(t);
    p   = 33'({r, 1'b0}) * 33'(mag);
    v   = (p + (33'd1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
    return t[15] ? -$signed(v[17:0]) : $signed(v[17:0]);
  endfunction

  logic signed [15:0] sc_sa_q;
  logic signed [15:0] sc_ca_q;
  logic signed [15:0] sc_sb_q;
  logic signed [15:0] sc_cb_q;
  logic signed [17:0] sc_ax_q;
  logic signed [17:0] sc_az_q;
  logic signed [17:0] sc_bx_q;
  logic signed [17:0] sc_bz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_valid_q <= 1'b0;
    end else if (en) begin
      sc_valid_q <= tr_a_valid && tr_b_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_sa_q <= sin_a;
      sc_ca_q <= cos_a;
      sc_sb_q <= sin_b;
      sc_cb_q <= cos_b;
      sc_ax_q <= scale_pos(sin_a, radius_q);
      sc_az_q <= scale_pos(cos_a, radius_q);
      sc_bx_q <= scale_pos(sin_b, radius_q);
      sc_bz_q <= scale_pos(cos_b, radius_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Vertex sequencer: hold one slice and walk its twelve vertices
  // ---------------------------------------------------------------------------
  logic signed [15:0] it_sa_q;
  logic signed [15:0] it_ca_q;
  logic signed [15:0] it_sb_q;
  logic signed [15:0] it_cb_q;
  logic signed [17:0] it_ax_q;
  logic signed [17:0] it_az_q;
  logic signed [17:0] it_bx_q;
  logic signed [17:0] it_bz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (seq_load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q && out_load) begin
      if (cnt_q == LAST_VTX) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_load) begin
      it_sa_q <= sc_sa_q;
      it_ca_q <= sc_ca_q;
      it_sb_q <= sc_sb_q;
      it_cb_q <= sc_cb_q;
      it_ax_q <= sc_ax_q;
      it_az_q <= sc_az_q;
      it_bx_q <= sc_bx_q;
      it_bz_q <= sc_bz_q;
    end
  end

  // pick the fields of the current vertex
  vtx_desc_t          desc;
  logic signed [16:0] y_top;
  logic signed [17:0] pos_x_d;
  logic signed [16:0] pos_y_d;
  logic signed [17:0] pos_z_d;
  logic signed [15:0] norm_x_d;
  logic signed [15:0] norm_y_d;
  logic signed [15:0] norm_z_d;

  assign desc  = vtx_desc(cnt_q);
  assign y_top = $signed({1'b0, height_q});

  always_comb begin
    case (desc.pt)
      PT_RIM_A: begin
        pos_x_d = it_ax_q;
        pos_z_d = it_az_q;
      end
      PT_RIM_B: begin
        pos_x_d = it_bx_q;
        pos_z_d = it_bz_q;
      end
      default: begin
        pos_x_d = '0;
        pos_z_d = '0;
      end
    endcase
    pos_y_d = desc.top ? y_top : -y_top;
    case (desc.nk)
      NK_SIDE: begin
        norm_x_d = (desc.pt == PT_RIM_B) ? it_sb_q : it_sa_q;
        norm_y_d = '0;
        norm_z_d = (desc.pt == PT_RIM_B) ? it_cb_q : it_ca_q;
      end
      NK_UP: begin
        norm_x_d = '0;
        norm_y_d = NORM_ONE;
        norm_z_d = '0;
      end
      default: begin
        norm_x_d = '0;
        norm_y_d = -NORM_ONE;
        norm_z_d = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic               out_valid_q;
  logic signed [17:0] pos_x_q;
  logic signed [16:0] pos_y_q;
  logic signed [17:0] pos_z_q;
  logic signed [15:0] norm_x_q;
  logic signed [15:0] norm_y_q;
  logic signed [15:0] norm_z_q;
  logic               last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && busy_q) begin
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      pos_z_q  <= pos_z_d;
      norm_x_q <= norm_x_d;
      norm_y_q <= norm_y_d;
      norm_z_q <= norm_z_d;
      last_q   <= (cnt_q == LAST_VTX);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = pos_x_q;
  assign pos_y_o       = pos_y_q;
  assign pos_z_o       = pos_z_q;
  assign norm_x_o      = norm_x_q;
  assign norm_y_o      = norm_y_q;
  assign norm_z_o      = norm_z_q;
  assign last_vertex_o = last_q;

`ifndef SYNTHESIS
  // the vertex counter never runs past the last vertex
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= LAST_VTX)
    else $error("vertex counter out of range");

  // a slice whose last vertex leaves frees the sequencer unless a new one enters
  a_seq_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_load && cnt_q == LAST_VTX && !seq_load) |=> !busy_q)
    else $error("sequencer not released after last vertex");

  // a held final stage keeps its item
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sc_valid_q && !en) |=> sc_valid_q)
    else $error("stalled slice lost");

  // a new slice is only taken while the sequencer is idle or finishing
  a_load_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_load && busy_q) |-> (cnt_q == LAST_VTX && out_load))
    else $error("slice overwritten in sequencer");
`endif

endmodule
`default_nettype wire
